FILE: hdl/mvn_pkg.sv
// ----------------------------------------------------------------------------
// mvn_pkg
// Shared types, sizes and codes of the vertex normal calculator.
// ----------------------------------------------------------------------------
`default_nettype none

package mvn_pkg;

  localparam int MAX_VERTICES  = 256;
  localparam int MAX_TRIANGLES = 512;
  localparam int VIDX_W        = 8;
  localparam int VCNT_W        = 9;
  localparam int TIDX_W        = 9;
  localparam int TCNT_W        = 10;
  localparam int VEC_W         = 36;  // signed width of a vector sent to normalization
  localparam int ACC_W         = 28;  // signed width of the face normal sum

  localparam logic [1:0] OP_LOAD_VERTEX = 2'd0;
  localparam logic [1:0] OP_LOAD_TRI    = 2'd1;
  localparam logic [1:0] OP_QUERY       = 2'd2;
  localparam logic [1:0] OP_CLEAR       = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  typedef logic signed [15:0]      coord_t;
  typedef logic [VIDX_W-1:0]       vidx_t;
  typedef logic signed [15:0]      q14_t;
  typedef logic signed [VEC_W-1:0] vec_t;

  typedef struct packed {
    logic start;
    vec_t x;
    vec_t y;
    vec_t z;
  } norm_req_t;

  typedef struct packed {
    logic done;
    q14_t x;
    q14_t y;
    q14_t z;
  } norm_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/mvn_if.sv
// ----------------------------------------------------------------------------
// mvn_in_if / mvn_out_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface mvn_in_if;
  import mvn_pkg::*;
  logic   valid;
  logic   ready;
  logic [1:0] opcode;
  coord_t coord_x;
  coord_t coord_y;
  coord_t coord_z;
  vidx_t  corner_a;
  vidx_t  corner_b;
  vidx_t  corner_c;
  modport source (output valid, opcode, coord_x, coord_y, coord_z,
                  corner_a, corner_b, corner_c, input ready);
  modport sink (input valid, opcode, coord_x, coord_y, coord_z,
                corner_a, corner_b, corner_c, output ready);
endinterface

interface mvn_out_if;
  import mvn_pkg::*;
  logic valid;
  logic ready;
  q14_t normal_x;
  q14_t normal_y;
  q14_t normal_z;
  logic [1:0] status;
  modport source (output valid, normal_x, normal_y, normal_z, status, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, status, output ready);
endinterface

`default_nettype wire

FILE: hdl/mvn_ram.sv
// ----------------------------------------------------------------------------
// mvn_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/mvn_mul.sv
// ----------------------------------------------------------------------------
// mvn_mul
// Shared signed 32x32 multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module mvn_mul (
  input  wire logic               clk,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic signed [63:0]      p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

`default_nettype wire

FILE: hdl/mvn_norm.sv
// ----------------------------------------------------------------------------
// mvn_norm
// Sequential vector normalization to Q1.14: magnitude prescale, sum of squares
// on the shared multiplier, bit-pair integer square root and restoring division.
// ----------------------------------------------------------------------------
`default_nettype none

module mvn_norm (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mvn_pkg::norm_req_t req,
  output mvn_pkg::norm_rsp_t      rsp,
  output logic signed [31:0]      mul_a,
  output logic signed [31:0]      mul_b,
  input  wire logic signed [63:0] mul_p
);
  import mvn_pkg::*;

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_SQRT  = 3'd3;
  localparam logic [2:0] N_DLOAD = 3'd4;
  localparam logic [2:0] N_DIV   = 3'd5;

  logic [2:0]       state_r;
  logic [VEC_W-1:0] m_r [3];
  logic [2:0]       neg_r;
  logic [61:0]      sum_r;
  logic [62:0]      x_r, r_r;
  logic [4:0]       k_r;
  logic [30:0]      len_r;
  logic [45:0]      num_r;
  logic [14:0]      q_r;
  logic [3:0]       i_r;
  logic [1:0]       j_r, step_r;
  q14_t             n_r [3];
  logic             done_r;

  logic [1:0]  sq_sel;
  logic [61:0] sum_fin;
  logic [62:0] bitv, trial, x_nxt, r_nxt;
  logic [45:0] dtrial;
  logic        dfit;
  logic [14:0] q_nxt;
  logic [15:0] q_ext;

  assign sq_sel  = (step_r == 2'd3) ? 2'd0 : step_r;
  assign mul_a   = {2'b00, m_r[sq_sel][29:0]};
  assign mul_b   = {2'b00, m_r[sq_sel][29:0]};
  assign sum_fin = sum_r + mul_p[61:0];

  always_comb begin
    bitv  = 63'(1) << {k_r, 1'b0};
    trial = r_r + bitv;
    if (x_r >= trial) begin
      x_nxt = x_r - trial;
      r_nxt = (r_r >> 1) + bitv;
    end else begin
      x_nxt = x_r;
      r_nxt = r_r >> 1;
    end
  end

  assign dtrial = {15'd0, len_r} << i_r;
  assign dfit   = (num_r >= dtrial);
  assign q_nxt  = q_r | (dfit ? (15'(1) << i_r) : 15'd0);
  assign q_ext  = {1'b0, q_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        N_IDLE: begin
          if (req.start) begin
            neg_r  <= {req.z[VEC_W-1], req.y[VEC_W-1], req.x[VEC_W-1]};
            m_r[0] <= req.x[VEC_W-1] ? -req.x : req.x;
            m_r[1] <= req.y[VEC_W-1] ? -req.y : req.y;
            m_r[2] <= req.z[VEC_W-1] ? -req.z : req.z;
            state_r <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          // Bring every magnitude below 2^30 so that the squares fit.
          if ((|m_r[0][VEC_W-1:30]) || (|m_r[1][VEC_W-1:30]) ||
              (|m_r[2][VEC_W-1:30])) begin
            m_r[0] <= m_r[0] >> 1;
            m_r[1] <= m_r[1] >> 1;
            m_r[2] <= m_r[2] >> 1;
          end else begin
            step_r  <= 2'd0;
            state_r <= N_SQ;
          end
        end
        N_SQ: begin
          step_r <= step_r + 2'd1;
          case (step_r)
            2'd0: sum_r <= '0;
            2'd1: sum_r <= mul_p[61:0];
            2'd2: sum_r <= sum_fin;
            default: begin
              if (sum_fin == '0) begin
                n_r[0]  <= '0;
                n_r[1]  <= '0;
                n_r[2]  <= '0;
                done_r  <= 1'b1;
                state_r <= N_IDLE;
              end else begin
                x_r     <= {1'b0, sum_fin};
                r_r     <= '0;
                k_r     <= 5'd31;
                state_r <= N_SQRT;
              end
            end
          endcase
        end
        N_SQRT: begin
          x_r <= x_nxt;
          r_r <= r_nxt;
          k_r <= k_r - 5'd1;
          if (k_r == 5'd0) begin
            len_r   <= r_nxt[30:0];
            j_r     <= 2'd0;
            state_r <= N_DLOAD;
          end
        end
        N_DLOAD: begin
          // Numerator m * 16384 + len / 2 gives round half away from zero.
          num_r   <= {2'b00, m_r[j_r][29:0], 14'd0} + {16'd0, len_r[30:1]};
          q_r     <= '0;
          i_r     <= 4'd14;
          state_r <= N_DIV;
        end
        N_DIV: begin
          if (dfit) begin
            num_r <= num_r - dtrial;
          end
          q_r <= q_nxt;
          i_r <= i_r - 4'd1;
          if (i_r == 4'd0) begin
            n_r[j_r] <= neg_r[j_r] ? -q_ext : q_ext;
            if (j_r == 2'd2) begin
              done_r  <= 1'b1;
              state_r <= N_IDLE;
            end else begin
              j_r     <= j_r + 2'd1;
              state_r <= N_DLOAD;
            end
          end
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.x    = n_r[0];
  assign rsp.y    = n_r[1];
  assign rsp.z    = n_r[2];

endmodule

`default_nettype wire

FILE: hdl/mesh_vertex_normal_calc_top.sv
// ----------------------------------------------------------------------------
// mesh_vertex_normal_calc_top
// Mesh store and query sequencer for vertex normals from summed face normals.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake    Word
//  in_ch    in   valid/ready  opcode, coord_x/y/z, corner_a/b/c
//  out_ch   out  valid/ready  normal_x/y/z, status
//
//  Loads, clears and rejected items answer in the cycle after they are taken.
//  A query walks every stored triangle, normalizes the face normal of each
//  triangle that uses the vertex and finally normalizes the sum; the shared
//  multiplier, the 32-step square root and 15-step divisions do that work.
//  Reset is synchronous and active low; the stores need no clearing.
//  A new word is taken only when idle and the previous result has been taken.
`default_nettype none

module mesh_vertex_normal_calc_top (
  input wire logic clk,
  input wire logic rst_n,
  mvn_in_if.sink   in_ch,
  mvn_out_if.source out_ch
);
  import mvn_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_TRI    = 4'd1;
  localparam logic [3:0] S_TWAIT  = 4'd2;
  localparam logic [3:0] S_V0     = 4'd3;
  localparam logic [3:0] S_V1     = 4'd4;
  localparam logic [3:0] S_V2     = 4'd5;
  localparam logic [3:0] S_CROSS  = 4'd6;
  localparam logic [3:0] S_NSTART = 4'd7;
  localparam logic [3:0] S_NWAIT  = 4'd8;

  logic [3:0]        state_r;
  logic [VCNT_W-1:0] vcnt_r;
  logic [TCNT_W-1:0] tcnt_r, t_r;
  vidx_t             qidx_r, cb_r, cc_r;
  logic [1:0]        hits_r;
  logic [47:0]       p1_r, p2_r;
  logic signed [16:0] u_r [3];
  logic signed [16:0] v_r [3];
  logic [2:0]        step_r;
  logic signed [34:0] tmp_r;
  vec_t              c_r [3];
  logic signed [ACC_W-1:0] acc_r [3];
  logic              final_r;
  logic              out_valid_r;
  q14_t              nx_r, ny_r, nz_r;
  logic [1:0]        status_r;

  logic              accept;
  logic              vram_we, tram_we;
  logic [47:0]       vram_rdata;
  logic [23:0]       tram_rdata;
  logic [VIDX_W-1:0] vram_raddr;
  vidx_t             ta, tb, tc;
  logic [1:0]        hits;
  logic signed [31:0] mul_a, mul_b, nmul_a, nmul_b;
  logic signed [63:0] mul_p;
  norm_req_t         nreq;
  norm_rsp_t         nrsp;
  logic              bad_tri;
  logic signed [ACC_W-1:0] fn_add [3];

  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;

  assign bad_tri = ({1'b0, in_ch.corner_a} >= vcnt_r) ||
                   ({1'b0, in_ch.corner_b} >= vcnt_r) ||
                   ({1'b0, in_ch.corner_c} >= vcnt_r);

  assign vram_we = accept && (in_ch.opcode == OP_LOAD_VERTEX) &&
                   (vcnt_r != VCNT_W'(MAX_VERTICES));
  assign tram_we = accept && (in_ch.opcode == OP_LOAD_TRI) &&
                   (tcnt_r != TCNT_W'(MAX_TRIANGLES)) && !bad_tri;

  assign ta = tram_rdata[7:0];
  assign tb = tram_rdata[15:8];
  assign tc = tram_rdata[23:16];
  assign hits = 2'((ta == qidx_r)) + 2'((tb == qidx_r)) + 2'((tc == qidx_r));

  always_comb begin
    unique case (state_r)
      S_V0:    vram_raddr = cb_r;
      S_V1:    vram_raddr = cc_r;
      default: vram_raddr = ta;
    endcase
  end

  mvn_ram #(.WIDTH(48), .DEPTH(MAX_VERTICES)) u_vram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vcnt_r[VIDX_W-1:0]),
    .wdata ({in_ch.coord_z, in_ch.coord_y, in_ch.coord_x}),
    .raddr (vram_raddr),
    .rdata (vram_rdata)
  );

  mvn_ram #(.WIDTH(24), .DEPTH(MAX_TRIANGLES)) u_tram (
    .clk   (clk),
    .we    (tram_we),
    .waddr (tcnt_r[TIDX_W-1:0]),
    .wdata ({in_ch.corner_c, in_ch.corner_b, in_ch.corner_a}),
    .raddr (t_r[TIDX_W-1:0]),
    .rdata (tram_rdata)
  );

  // Cross product terms go through the multiplier in a fixed order.
  always_comb begin
    if (state_r == S_CROSS) begin
      case (step_r)
        3'd0:    begin mul_a = 32'(u_r[1]); mul_b = 32'(v_r[2]); end
        3'd1:    begin mul_a = 32'(u_r[2]); mul_b = 32'(v_r[1]); end
        3'd2:    begin mul_a = 32'(u_r[2]); mul_b = 32'(v_r[0]); end
        3'd3:    begin mul_a = 32'(u_r[0]); mul_b = 32'(v_r[2]); end
        3'd4:    begin mul_a = 32'(u_r[0]); mul_b = 32'(v_r[1]); end
        default: begin mul_a = 32'(u_r[1]); mul_b = 32'(v_r[0]); end
      endcase
    end else begin
      mul_a = nmul_a;
      mul_b = nmul_b;
    end
  end

  mvn_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  assign nreq.start = (state_r == S_NSTART);
  assign nreq.x     = final_r ? VEC_W'(acc_r[0]) : c_r[0];
  assign nreq.y     = final_r ? VEC_W'(acc_r[1]) : c_r[1];
  assign nreq.z     = final_r ? VEC_W'(acc_r[2]) : c_r[2];

  mvn_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (nreq),
    .rsp   (nrsp),
    .mul_a (nmul_a),
    .mul_b (nmul_b),
    .mul_p (mul_p)
  );

  // A face normal counts once for every corner that names the vertex.
  always_comb begin
    logic signed [ACC_W-1:0] f [3];
    f[0] = ACC_W'(nrsp.x);
    f[1] = ACC_W'(nrsp.y);
    f[2] = ACC_W'(nrsp.z);
    for (int k = 0; k < 3; k++) begin
      case (hits_r)
        2'd1:    fn_add[k] = f[k];
        2'd2:    fn_add[k] = f[k] <<< 1;
        default: fn_add[k] = f[k] + (f[k] <<< 1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcnt_r      <= '0;
      tcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            nx_r     <= '0;
            ny_r     <= '0;
            nz_r     <= '0;
            status_r <= ST_OK;
            unique case (in_ch.opcode)
              OP_LOAD_VERTEX: begin
                out_valid_r <= 1'b1;
                if (vcnt_r == VCNT_W'(MAX_VERTICES)) begin
                  status_r <= ST_FULL;
                end else begin
                  vcnt_r <= vcnt_r + VCNT_W'(1);
                end
              end
              OP_LOAD_TRI: begin
                out_valid_r <= 1'b1;
                if (tcnt_r == TCNT_W'(MAX_TRIANGLES)) begin
                  status_r <= ST_FULL;
                end else if (bad_tri) begin
                  status_r <= ST_BAD_INDEX;
                end else begin
                  tcnt_r <= tcnt_r + TCNT_W'(1);
                end
              end
              OP_QUERY: begin
                if ({1'b0, in_ch.corner_a} >= vcnt_r) begin
                  status_r    <= ST_BAD_INDEX;
                  out_valid_r <= 1'b1;
                end else begin
                  qidx_r   <= in_ch.corner_a;
                  t_r      <= '0;
                  acc_r[0] <= '0;
                  acc_r[1] <= '0;
                  acc_r[2] <= '0;
                  state_r  <= S_TRI;
                end
              end
              default: begin
                out_valid_r <= 1'b1;
                vcnt_r      <= '0;
                tcnt_r      <= '0;
              end
            endcase
          end
        end
        S_TRI: begin
          if (t_r == tcnt_r) begin
            final_r <= 1'b1;
            state_r <= S_NSTART;
          end else begin
            state_r <= S_TWAIT;
          end
        end
        S_TWAIT: begin
          if (hits == 2'd0) begin
            t_r     <= t_r + TCNT_W'(1);
            state_r <= S_TRI;
          end else begin
            hits_r  <= hits;
            cb_r    <= tb;
            cc_r    <= tc;
            state_r <= S_V0;
          end
        end
        S_V0: begin
          p1_r    <= vram_rdata;
          state_r <= S_V1;
        end
        S_V1: begin
          p2_r    <= vram_rdata;
          state_r <= S_V2;
        end
        S_V2: begin
          for (int k = 0; k < 3; k++) begin
            u_r[k] <= 17'(signed'(p2_r[16*k +: 16])) - 17'(signed'(p1_r[16*k +: 16]));
            v_r[k] <= 17'(signed'(vram_rdata[16*k +: 16])) -
                      17'(signed'(p1_r[16*k +: 16]));
          end
          step_r  <= '0;
          state_r <= S_CROSS;
        end
        S_CROSS: begin
          step_r <= step_r + 3'd1;
          case (step_r)
            3'd1, 3'd3, 3'd5: tmp_r <= mul_p[34:0];
            3'd2: c_r[0] <= VEC_W'(tmp_r) - VEC_W'(signed'(mul_p[34:0]));
            3'd4: c_r[1] <= VEC_W'(tmp_r) - VEC_W'(signed'(mul_p[34:0]));
            3'd6: begin
              c_r[2]  <= VEC_W'(tmp_r) - VEC_W'(signed'(mul_p[34:0]));
              final_r <= 1'b0;
              state_r <= S_NSTART;
            end
            default: ;
          endcase
        end
        S_NSTART: begin
          state_r <= S_NWAIT;
        end
        S_NWAIT: begin
          if (nrsp.done) begin
            if (final_r) begin
              nx_r        <= nrsp.x;
              ny_r        <= nrsp.y;
              nz_r        <= nrsp.z;
              status_r    <= ST_OK;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              for (int k = 0; k < 3; k++) begin
                acc_r[k] <= acc_r[k] + fn_add[k];
              end
              t_r     <= t_r + TCNT_W'(1);
              state_r <= S_TRI;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.normal_x = nx_r;
  assign out_ch.normal_y = ny_r;
  assign out_ch.normal_z = nz_r;
  assign out_ch.status   = status_r;

endmodule

`default_nettype wire
